// ===== hdl/usv_pkg.sv =====
// Shared types, constants and rounding helpers for the UV sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none

package usv_pkg;

    // Field and register widths.
    localparam int CNT_W = 11;
    localparam int IDX_W = 11;
    localparam int RAD_W = 16;
    localparam int VNUM_W = 21;
    localparam int TEX_W = 17;
    localparam int POS_W = 17;
    localparam int NRM_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults.
    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int MAX_RINGS_DEF = 1024;

    // Register reset values.
    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [CNT_W-1:0] SEGMENTS_RST = 11'd16;
    localparam logic [CNT_W-1:0] RINGS_RST = 11'd16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS   = 2'd0,
        CFG_SEGMENTS = 2'd1,
        CFG_RINGS    = 2'd2
    } cfg_reg_t;

    // Pipeline latencies.
    localparam int DIV_LAT = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;

    // CORDIC start vector (gain-compensated 1.0 in Q2.30) and arctangent table in turn units.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
        32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
        32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
        32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
        32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41,
        32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1
    };

    // Grid indexes that travel beside the math.
    typedef struct packed {
        logic [VNUM_W-1:0] vnum;
        logic [VNUM_W-1:0] lower;
        logic              quad;
    } side_t;

    // Texture coordinates that travel beside the CORDIC.
    typedef struct packed {
        logic [TEX_W-1:0] u;
        logic [TEX_W-1:0] v;
    } tex_t;

    // Q30 to Q8.8 position: round(radius*n / 2^30), clamped to +-65535.
    function automatic logic signed [POS_W-1:0] pos_round(
        input logic [RAD_W-1:0] rad,
        input logic signed [31:0] n
    );
        logic signed [16:0] rad_s;
        logic signed [48:0] prod;
        logic signed [48:0] sh;
        rad_s = $signed({1'b0, rad});
        prod = rad_s * n;
        sh = (prod + 49'sd536870912) >>> 30;
        if (sh > 49'sd65535)
            return 17'sd65535;
        else if (sh < -49'sd65535)
            return -17'sd65535;
        else
            return sh[POS_W-1:0];
    endfunction

    // Q30 to Q1.14 normal: round(n / 2^16), clamped to +-16384.
    function automatic logic signed [NRM_W-1:0] nrm_round(input logic signed [31:0] n);
        logic signed [32:0] w;
        w = ($signed({n[31], n}) + 33'sd32768) >>> 16;
        if (w > 33'sd16384)
            return 16'sd16384;
        else if (w < -33'sd16384)
            return -16'sd16384;
        else
            return w[NRM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/usv_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, remainder kept below the divisor.
`timescale 1ns / 1ps
`default_nettype none

module usv_divider #(
    parameter int QBITS = 32,
    parameter int LAT = 32
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [usv_pkg::CNT_W-1:0] rem_in,
    input  wire logic                     quo_hi,
    input  wire logic [QBITS-1:0]         addend,
    input  wire logic [usv_pkg::CNT_W-1:0] divisor,
    output logic      [QBITS:0]           quo
);
    import usv_pkg::*;

    logic [CNT_W-1:0] rem_s [0:LAT];
    logic [QBITS:0]   quo_s [0:LAT];

    assign rem_s[0] = rem_in;
    assign quo_s[0] = {{QBITS{1'b0}}, quo_hi};

    // One stage per quotient bit; stages past the quotient width only align latency.
    for (genvar k = 0; k < LAT; k++) begin : g_stage
        logic [CNT_W-1:0] rem_next;
        logic [QBITS:0]   quo_next;

        if (k < QBITS) begin : g_step
            logic [CNT_W:0] trial;
            logic           ge;
            always_comb
            begin
                trial = {rem_s[k], addend[QBITS-1-k]};
                ge = (trial >= {1'b0, divisor});
                rem_next = ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
                quo_next = {quo_s[k][QBITS-1:0], ge};
            end
        end else begin : g_pass
            always_comb
            begin
                rem_next = rem_s[k];
                quo_next = quo_s[k];
            end
        end

        // Stage register.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_s[k+1] <= rem_next;
                quo_s[k+1] <= quo_next;
            end
        end
    end

    assign quo = quo_s[LAT];

endmodule

`default_nettype wire

// ===== hdl/usv_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine in Q30 of a 32-bit turn phase.
`timescale 1ns / 1ps
`default_nettype none

module usv_cordic (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic        [31:0] phase,
    output logic signed      [31:0] cos_out,
    output logic signed      [31:0] sin_out
);
    import usv_pkg::*;

    logic signed [31:0] x_s [0:CORDIC_STEPS];
    logic signed [31:0] y_s [0:CORDIC_STEPS];
    logic signed [31:0] z_s [0:CORDIC_STEPS];
    logic        [1:0]  quad_s [0:CORDIC_STEPS];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;

    // The top two bits pick the quadrant; the rest is the angle below 90 degrees.
    assign x_s[0] = CORDIC_GAIN;
    assign y_s[0] = 32'sd0;
    assign z_s[0] = $signed({2'b00, phase[29:0]});
    assign quad_s[0] = phase[31:30];

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        assign dx = y_s[i] >>> i;
        assign dy = x_s[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_s[i][31])
                begin
                    x_s[i+1] <= x_s[i] - dx;
                    y_s[i+1] <= y_s[i] + dy;
                    z_s[i+1] <= z_s[i] - ATAN_TURN[i];
                end
                else
                begin
                    x_s[i+1] <= x_s[i] + dx;
                    y_s[i+1] <= y_s[i] - dy;
                    z_s[i+1] <= z_s[i] + ATAN_TURN[i];
                end
                quad_s[i+1] <= quad_s[i];
            end
        end
    end

    // Rotate the result by the quadrant.
    always_comb
    begin
        unique case (quad_s[CORDIC_STEPS])
            2'd0:
            begin
                cos_next = x_s[CORDIC_STEPS];
                sin_next = y_s[CORDIC_STEPS];
            end
            2'd1:
            begin
                cos_next = -y_s[CORDIC_STEPS];
                sin_next = x_s[CORDIC_STEPS];
            end
            2'd2:
            begin
                cos_next = -x_s[CORDIC_STEPS];
                sin_next = -y_s[CORDIC_STEPS];
            end
            default:
            begin
                cos_next = y_s[CORDIC_STEPS];
                sin_next = -x_s[CORDIC_STEPS];
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

`default_nettype wire

// ===== hdl/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex generator: configuration, clamping and the vertex pipeline.
//
// Channel   Direction  Handshake                Payload
// item      in         item_valid/item_stall    ring_index, segment_index
// vertex    out        vertex_valid/vertex_stall pos, normal, tex, vertex numbers, quad_valid
// cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One transaction enters per cycle while the pipeline is not held; each passes in order through
// the input register, the 32-stage bit-per-stage dividers, the 31-stage CORDIC and two multiply stages.
// The whole pipeline advances together; it holds only while a result waits under vertex_stall.
// Reset clears the valid bits and loads the registers with radius 1.0 and 16 by 16 segments.
// Configuration writes are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none

module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS = usv_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_RINGS = usv_pkg::MAX_RINGS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [usv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [usv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [usv_pkg::IDX_W-1:0]      ring_index,
    input  wire logic [usv_pkg::IDX_W-1:0]      segment_index,
    output logic                                vertex_valid,
    input  wire logic                           vertex_stall,
    output logic signed [usv_pkg::POS_W-1:0]    pos_x,
    output logic signed [usv_pkg::POS_W-1:0]    pos_y,
    output logic signed [usv_pkg::POS_W-1:0]    pos_z,
    output logic signed [usv_pkg::NRM_W-1:0]    normal_x,
    output logic signed [usv_pkg::NRM_W-1:0]    normal_y,
    output logic signed [usv_pkg::NRM_W-1:0]    normal_z,
    output logic        [usv_pkg::TEX_W-1:0]    tex_u,
    output logic        [usv_pkg::TEX_W-1:0]    tex_v,
    output logic        [usv_pkg::VNUM_W-1:0]   vertex_number,
    output logic        [usv_pkg::VNUM_W-1:0]   lower_vertex_number,
    output logic                                quad_valid
);
    import usv_pkg::*;

    localparam int SIDE_LAT = 1 + DIV_LAT + CORDIC_LAT;
    localparam int TEX_LAT = CORDIC_LAT + 1;
    localparam int PIPE_LAT = SIDE_LAT + 1;

    // Configuration registers.
    logic [RAD_W-1:0] radius_reg;
    logic [CNT_W-1:0] seg_cnt_reg;
    logic [CNT_W-1:0] ring_cnt_reg;
    logic [CNT_W-1:0] eff_s;
    logic [CNT_W-1:0] eff_r;

    // Pipeline control.
    logic                en;
    logic                vld_reg [0:PIPE_LAT-1];
    logic                out_valid_reg;

    // Input stage.
    logic [IDX_W-1:0] ring_clamp;
    logic [IDX_W-1:0] seg_clamp;
    logic [IDX_W-1:0] ring_p0_reg;
    logic [IDX_W-1:0] seg_p0_reg;

    // Divider feeds and results.
    logic               seg_full;
    logic               ring_full;
    logic [CNT_W-1:0]   seg_rem0;
    logic [CNT_W-1:0]   ring_rem0;
    logic [32:0]        th_quo;
    logic [31:0]        ph_quo;
    logic [TEX_W-1:0]   tu_quo;
    logic [TEX_W-1:0]   tv_quo;

    // Trig results.
    logic signed [31:0] ct;
    logic signed [31:0] st;
    logic signed [31:0] cp;
    logic signed [31:0] sp;

    // Side data.
    side_t side_next;
    side_t side_reg [0:SIDE_LAT-1];
    tex_t  tex_reg [0:TEX_LAT-1];
    logic [VNUM_W+2:0] vnum_full;

    // Normal stage.
    logic signed [63:0] prod_x;
    logic signed [63:0] prod_z;
    logic signed [31:0] nx_reg;
    logic signed [31:0] ny_reg;
    logic signed [31:0] nz_reg;

    // Output registers.
    logic signed [POS_W-1:0]  pos_x_reg;
    logic signed [POS_W-1:0]  pos_y_reg;
    logic signed [POS_W-1:0]  pos_z_reg;
    logic signed [NRM_W-1:0]  nrm_x_reg;
    logic signed [NRM_W-1:0]  nrm_y_reg;
    logic signed [NRM_W-1:0]  nrm_z_reg;
    logic        [TEX_W-1:0]  tex_u_reg;
    logic        [TEX_W-1:0]  tex_v_reg;
    logic        [VNUM_W-1:0] vnum_reg;
    logic        [VNUM_W-1:0] lower_reg;
    logic                     quad_reg;

    // Configuration writes; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            seg_cnt_reg <= SEGMENTS_RST;
            ring_cnt_reg <= RINGS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RADIUS:   radius_reg <= cfg_data[RAD_W-1:0];
                CFG_SEGMENTS: seg_cnt_reg <= cfg_data[CNT_W-1:0];
                CFG_RINGS:    ring_cnt_reg <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective counts: zero acts as one, large counts saturate at the maximum.
    always_comb
    begin
        if (seg_cnt_reg == '0)
            eff_s = CNT_W'(1);
        else if (32'(seg_cnt_reg) > MAX_SEGMENTS)
            eff_s = CNT_W'(MAX_SEGMENTS);
        else
            eff_s = seg_cnt_reg;

        if (ring_cnt_reg == '0)
            eff_r = CNT_W'(1);
        else if (32'(ring_cnt_reg) > MAX_RINGS)
            eff_r = CNT_W'(MAX_RINGS);
        else
            eff_r = ring_cnt_reg;
    end

    // The pipeline moves unless a finished result is held by the receiver.
    assign en = !(out_valid_reg && vertex_stall);
    assign item_stall = !en;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LAT; k++)
                vld_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k < PIPE_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    // Clamp indexes to the effective counts and register them.
    assign ring_clamp = (ring_index > eff_r) ? eff_r : ring_index;
    assign seg_clamp = (segment_index > eff_s) ? eff_s : segment_index;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ring_p0_reg <= ring_clamp;
            seg_p0_reg <= seg_clamp;
        end
    end

    // An index equal to its count gives a whole quotient bit and zero remainder.
    assign seg_full = (seg_p0_reg == eff_s);
    assign ring_full = (ring_p0_reg == eff_r);
    assign seg_rem0 = seg_full ? '0 : seg_p0_reg;
    assign ring_rem0 = ring_full ? '0 : ring_p0_reg;

    // Theta phase: round(seg * 2^32 / S), wrapped to one turn.
    usv_divider #(.QBITS(32), .LAT(DIV_LAT)) u_div_theta (
        .clk     (clk),
        .en      (en),
        .rem_in  (seg_rem0),
        .quo_hi  (seg_full),
        .addend  (32'(eff_s[CNT_W-1:1])),
        .divisor (eff_s),
        .quo     (th_quo)
    );

    // Phi phase: round(ring * 2^31 / R).
    usv_divider #(.QBITS(31), .LAT(DIV_LAT)) u_div_phi (
        .clk     (clk),
        .en      (en),
        .rem_in  (ring_rem0),
        .quo_hi  (ring_full),
        .addend  (31'(eff_r[CNT_W-1:1])),
        .divisor (eff_r),
        .quo     (ph_quo)
    );

    // Texture coordinates: round(index * 2^16 / count).
    usv_divider #(.QBITS(16), .LAT(DIV_LAT)) u_div_u (
        .clk     (clk),
        .en      (en),
        .rem_in  (seg_rem0),
        .quo_hi  (seg_full),
        .addend  (16'(eff_s[CNT_W-1:1])),
        .divisor (eff_s),
        .quo     (tu_quo)
    );

    usv_divider #(.QBITS(16), .LAT(DIV_LAT)) u_div_v (
        .clk     (clk),
        .en      (en),
        .rem_in  (ring_rem0),
        .quo_hi  (ring_full),
        .addend  (16'(eff_r[CNT_W-1:1])),
        .divisor (eff_r),
        .quo     (tv_quo)
    );

    // Sine and cosine of both angles.
    usv_cordic u_cordic_theta (
        .clk     (clk),
        .en      (en),
        .phase   (th_quo[31:0]),
        .cos_out (ct),
        .sin_out (st)
    );

    usv_cordic u_cordic_phi (
        .clk     (clk),
        .en      (en),
        .phase   (ph_quo),
        .cos_out (cp),
        .sin_out (sp)
    );

    // Vertex numbers and the quad flag.
    always_comb
    begin
        vnum_full = (VNUM_W+3)'(ring_p0_reg) * ((VNUM_W+3)'(eff_s) + (VNUM_W+3)'(1))
                    + (VNUM_W+3)'(seg_p0_reg);
        side_next.vnum = vnum_full[VNUM_W-1:0];
        side_next.quad = (ring_p0_reg < eff_r) && (seg_p0_reg < eff_s);
        side_next.lower = side_next.quad ?
            VNUM_W'(vnum_full[VNUM_W-1:0] + VNUM_W'(eff_s) + VNUM_W'(1)) : '0;
    end

    // Delay lines that keep side data level with the trig results.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_LAT; k++)
                side_reg[k] <= side_reg[k-1];
            tex_reg[0] <= '{u: tu_quo, v: tv_quo};
            for (int k = 1; k < TEX_LAT; k++)
                tex_reg[k] <= tex_reg[k-1];
        end
    end

    // Unit normal in Q30.
    assign prod_x = sp * ct;
    assign prod_z = sp * st;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= 32'((prod_x + 64'sd536870912) >>> 30);
            ny_reg <= cp;
            nz_reg <= 32'((prod_z + 64'sd536870912) >>> 30);
        end
    end

    // Scale by the radius, round and clamp into the output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg <= pos_round(radius_reg, nx_reg);
            pos_y_reg <= pos_round(radius_reg, ny_reg);
            pos_z_reg <= pos_round(radius_reg, nz_reg);
            nrm_x_reg <= nrm_round(nx_reg);
            nrm_y_reg <= nrm_round(ny_reg);
            nrm_z_reg <= nrm_round(nz_reg);
            tex_u_reg <= tex_reg[TEX_LAT-1].u;
            tex_v_reg <= tex_reg[TEX_LAT-1].v;
            vnum_reg <= side_reg[SIDE_LAT-1].vnum;
            lower_reg <= side_reg[SIDE_LAT-1].lower;
            quad_reg <= side_reg[SIDE_LAT-1].quad;
        end
    end

    assign vertex_valid = out_valid_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;
    assign normal_x = nrm_x_reg;
    assign normal_y = nrm_y_reg;
    assign normal_z = nrm_z_reg;
    assign tex_u = tex_u_reg;
    assign tex_v = tex_v_reg;
    assign vertex_number = vnum_reg;
    assign lower_vertex_number = lower_reg;
    assign quad_valid = quad_reg;

`ifndef NO_ASSERTIONS
    // An accepted transaction occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    // A quad's lower vertex sits one ring further down.
    a_quad_lower: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && quad_valid |->
            lower_vertex_number == VNUM_W'(vertex_number + VNUM_W'(eff_s) + VNUM_W'(1)))
        else $error("lower vertex number does not match the ring stride");

    // Without a quad the lower vertex number is zero.
    a_no_quad: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !quad_valid |-> lower_vertex_number == '0)
        else $error("lower vertex number set without a quad");

    // Texture coordinates never pass 1.0.
    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
        else $error("texture coordinate above 1.0");
`endif

endmodule

`default_nettype wire
